### src/hces_pkg.sv
package hces_pkg;

  localparam int RATE_W = 17;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int CONF_W = 4;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam logic [RATE_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RISE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FALL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 3'd6;

  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic [RATE_W-1:0] rate;
    logic round_end;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] order_color;
    logic [IDX_W-1:0] hottest_color;
    logic hottest_changed;
    logic order_changed;
    logic last_rank;
  } out_item_t;

  function automatic logic [RATE_W-1:0] sat_q16(input logic [RATE_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

### src/hces_stream_if.sv
interface hces_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### src/hot_color_ewma_selector_core.sv
// Ranks up to 16 cache colors by a smoothed eviction rate, once per measurement round.
// Each request stores one color's rate; a request with round_end closes the round. The
// block then updates the averages in memory (per color: memory read, the two weighted
// products summed, or the rate itself in the first round, write back), sorts them by an
// insertion sort over the memory (per color a fetch of its average, then one read of the
// neighbour's average per compare and shift), decides the hottest color, builds the order
// and emits n rank results, one per cycle while out_ready is high. Averages read as zero
// until first written, tracked by one valid bit per color. While a round is processed no
// new request is accepted.
module hot_color_ewma_selector_core #(
  parameter int MAX_COLORS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [hces_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hces_pkg::CFG_DATA_W-1:0] cfg_data,
  hces_stream_if.sink in_ch,
  hces_stream_if.source out_ch
);

  localparam int AW = (MAX_COLORS > 16) ? $clog2(MAX_COLORS) : 4;
  localparam int NC = (MAX_COLORS > 16) ? 16 : MAX_COLORS;
  localparam int RW = hces_pkg::RATE_W;
  localparam int IW = hces_pkg::IDX_W;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_URD  = 9'b000000010,
    ST_UMUL = 9'b000000100,
    ST_UWR  = 9'b000001000,
    ST_SRD  = 9'b000010000,
    ST_SCMP = 9'b000100000,
    ST_HOT  = 9'b001000000,
    ST_ORD  = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  logic [4:0] color_count_r;
  logic [RW-1:0] weight_rise_r, weight_fall_r, lvl1_r, lvl2_r, lvl3_r;
  logic [3:0] confirm_r;

  logic [RW-1:0] pend_mem [16];
  logic [RW-1:0] avg_mem [16];
  logic [IW-1:0] prev_order_r [16];
  logic [IW-1:0] sorted_r [16];
  logic [IW-1:0] order_r [16];

  state_t state_r;
  logic primed_r;
  logic [IW-1:0] hottest_r, prev_leader_r;
  logic [3:0] lead_r;
  logic [4:0] n_r;
  logic [4:0] i_r, j_r, k_r;
  logic [RW-1:0] pend_q, avg_q, cur_avg_r, cmp_avg_r;
  logic [33:0] prod_r;
  logic [IW-1:0] cand_r;
  logic hot_chg_r, ord_chg_r;
  logic [RW-1:0] cand_avg_r;

  logic [AW-1:0] rd_addr;
  logic [IW-1:0] rd_a;
  logic avg_we;
  logic [IW-1:0] avg_wa;
  logic [RW-1:0] avg_wd;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_EMIT);
  assign rd_a = rd_addr[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= 5'd16;
      weight_rise_r <= 17'd55706;
      weight_fall_r <= 17'd55706;
      lvl1_r <= 17'd26214;
      lvl2_r <= 17'd42598;
      lvl3_r <= 17'd55706;
      confirm_r <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        hces_pkg::REG_COLOR_COUNT: color_count_r <= cfg_data[4:0];
        hces_pkg::REG_WEIGHT_RISE: weight_rise_r <= cfg_data;
        hces_pkg::REG_WEIGHT_FALL: weight_fall_r <= cfg_data;
        hces_pkg::REG_LEVEL_ONE: lvl1_r <= cfg_data;
        hces_pkg::REG_LEVEL_TWO: lvl2_r <= cfg_data;
        hces_pkg::REG_LEVEL_THREE: lvl3_r <= cfg_data;
        hces_pkg::REG_CONFIRM: confirm_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  function automatic logic [2:0] level_of(input logic [RW-1:0] a, input logic [RW-1:0] b1,
                                          input logic [RW-1:0] b2, input logic [RW-1:0] b3);
    if (a >= b3) return 3'd3;
    if (a >= b2) return 3'd2;
    if (a >= b1) return 3'd1;
    return 3'd0;
  endfunction

  // memories
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && (32'(in_ch.data.color_index) < MAX_COLORS))
      pend_mem[in_ch.data.color_index] <= hces_pkg::sat_q16(in_ch.data.rate);
    pend_q <= pend_mem[rd_a];
  end

  logic [15:0] avg_vld_r;
  logic [RW-1:0] avg_rd_r;
  logic avg_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_vld_r <= '0;
    end else if (avg_we) begin
      avg_vld_r[avg_wa] <= 1'b1;
    end
    if (avg_we) avg_mem[avg_wa] <= avg_wd;
    avg_rd_r <= avg_mem[rd_a];
    avg_hit_r <= avg_vld_r[rd_a];
  end

  assign avg_q = avg_hit_r ? avg_rd_r : '0;

  // read address
  always_comb begin
    rd_addr = '0;
    case (state_r)
      ST_IDLE, ST_URD: rd_addr = AW'(i_r);
      ST_UWR:          rd_addr = AW'(i_r);
      ST_SRD:          rd_addr = AW'(i_r);
      ST_SCMP:         rd_addr = AW'(sorted_r[j_r[3:0] - 4'd1]);
      ST_HOT:          rd_addr = (k_r == 5'd0) ? AW'(sorted_r[0]) : AW'(hottest_r);
      default:         rd_addr = AW'(i_r);
    endcase
  end

  logic [RW-1:0] w_sat;
  logic [33:0] ewma_sum;
  logic [RW-1:0] ewma_new;
  assign w_sat = hces_pkg::sat_q16((pend_q > avg_q) ? weight_rise_r : weight_fall_r);
  assign ewma_sum = prod_r + 34'd32768;
  assign ewma_new = hces_pkg::sat_q16(ewma_sum[32:16]);

  always_comb begin
    avg_we = 1'b0;
    avg_wa = i_r[IW-1:0];
    avg_wd = ewma_new;
    if (state_r == ST_UWR) avg_we = 1'b1;
  end

  logic [3:0] need;
  logic [2:0] top_lvl, hot_lvl;
  logic lead_ok;
  assign need = (confirm_r == 4'd0) ? 4'd1 : confirm_r;
  assign top_lvl = level_of(cmp_avg_r, lvl1_r, lvl2_r, lvl3_r);
  assign hot_lvl = level_of(avg_q, lvl1_r, lvl2_r, lvl3_r);
  assign lead_ok = (cand_r != hottest_r) && (top_lvl >= hot_lvl + 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      primed_r <= 1'b0;
      hottest_r <= '0;
      prev_leader_r <= '0;
      lead_r <= '0;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      n_r <= 5'd1;
      for (int q = 0; q < 16; q++) prev_order_r[q] <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.data.round_end) begin
            state_r <= ST_URD;
            i_r <= '0;
            if (color_count_r == 5'd0) n_r <= 5'd1;
            else if (color_count_r > 5'(NC)) n_r <= 5'(NC);
            else n_r <= color_count_r;
          end
        end
        ST_URD: state_r <= ST_UMUL;
        ST_UMUL: begin
          // primed: w*old + (1-w)*rate ; first round: rate << 16
          if (primed_r)
            prod_r <= 34'(w_sat) * 34'(avg_q) + 34'(hces_pkg::ONE_Q16 - w_sat) * 34'(pend_q);
          else
            prod_r <= {1'b0, pend_q, 16'd0};
          state_r <= ST_UWR;
        end
        ST_UWR: begin
          if (i_r + 5'd1 == n_r) begin
            i_r <= 5'd0;
            state_r <= ST_SRD;
          end else begin
            i_r <= i_r + 5'd1;
            state_r <= ST_URD;
          end
        end
        ST_SRD: begin
          // avg of color i arrives next cycle as cur
          state_r <= ST_SCMP;
          j_r <= i_r;
          k_r <= 5'd0;
        end
        ST_SCMP: begin
          if (k_r == 5'd0) begin
            cur_avg_r <= avg_q;
            k_r <= 5'd1;
            if (j_r == 5'd0) begin
              sorted_r[0] <= i_r[IW-1:0];
              k_r <= 5'd0;
              if (i_r + 5'd1 == n_r) state_r <= ST_HOT;
              else begin
                i_r <= i_r + 5'd1;
                state_r <= ST_SRD;
              end
            end
          end else if (k_r == 5'd1) begin
            k_r <= 5'd2;
          end else begin
            // avg_q holds avg of sorted[j-1]
            if (avg_q < cur_avg_r) begin
              sorted_r[j_r[3:0]] <= sorted_r[j_r[3:0] - 4'd1];
              j_r <= j_r - 5'd1;
              if (j_r == 5'd1) begin
                sorted_r[0] <= i_r[IW-1:0];
                k_r <= 5'd0;
                if (i_r + 5'd1 == n_r) state_r <= ST_HOT;
                else begin
                  i_r <= i_r + 5'd1;
                  state_r <= ST_SRD;
                end
              end else k_r <= 5'd1;
            end else begin
              sorted_r[j_r[3:0]] <= i_r[IW-1:0];
              k_r <= 5'd0;
              if (i_r + 5'd1 == n_r) state_r <= ST_HOT;
              else begin
                i_r <= i_r + 5'd1;
                state_r <= ST_SRD;
              end
            end
          end
        end
        ST_HOT: begin
          // k 0: issue reads; 1: take candidate avg; 2: move it to compare; 3: decide
          if (k_r == 5'd0) begin
            cand_r <= sorted_r[0];
            k_r <= 5'd1;
          end else if (k_r == 5'd1) begin
            k_r <= 5'd2;
            cand_avg_r <= avg_q;
          end else if (k_r == 5'd2) begin
            k_r <= 5'd3;
            cmp_avg_r <= cand_avg_r;
          end else begin
            hot_chg_r <= 1'b0;
            if (!primed_r) begin
              hottest_r <= cand_r;
              prev_leader_r <= cand_r;
              lead_r <= '0;
              hot_chg_r <= 1'b1;
            end else begin : decide
              logic [3:0] lc;
              lc = lead_r;
              if (lead_ok) begin
                if (cand_r == prev_leader_r) begin
                  if (lc < 4'd15) lc = lc + 4'd1;
                end else lc = 4'd1;
              end else lc = 4'd0;
              prev_leader_r <= cand_r;
              if (lc >= need) begin
                hottest_r <= cand_r;
                lc = 4'd0;
                hot_chg_r <= 1'b1;
              end
              lead_r <= lc;
            end
            k_r <= 5'd0;
            i_r <= 5'd0;
            j_r <= 5'd1;
            ord_chg_r <= !primed_r;
            state_r <= ST_ORD;
          end
        end
        ST_ORD: begin
          if (i_r == 5'd0 && j_r == 5'd1 && k_r == 5'd0) begin
            order_r[0] <= hottest_r;
            k_r <= 5'd1;
          end
          if (i_r == n_r || j_r == n_r) begin
            state_r <= ST_EMIT;
            i_r <= 5'd0;
          end else begin
            if (sorted_r[i_r[3:0]] != hottest_r) begin
              order_r[j_r[3:0]] <= sorted_r[i_r[3:0]];
              j_r <= j_r + 5'd1;
            end
            i_r <= i_r + 5'd1;
          end
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            prev_order_r[i_r[3:0]] <= order_r[i_r[3:0]];
            if (i_r + 5'd1 == n_r) begin
              state_r <= ST_IDLE;
              primed_r <= 1'b1;
              i_r <= 5'd0;
            end else i_r <= i_r + 5'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // rank 0 always holds the hottest color
  logic ord_diff;
  always_comb begin
    ord_diff = 1'b0;
    for (int q = 0; q < 16; q++)
      if ((5'(q) < n_r) && (((q == 0) ? hottest_r : order_r[q]) != prev_order_r[q]))
        ord_diff = 1'b1;
  end

  logic oc_r;
  always_ff @(posedge clk) begin
    if (state_r != ST_EMIT) oc_r <= ord_chg_r | ord_diff;
  end

  assign out_ch.data.position = i_r[IW-1:0];
  assign out_ch.data.order_color = order_r[i_r[3:0]];
  assign out_ch.data.hottest_color = hottest_r;
  assign out_ch.data.hottest_changed = hot_chg_r;
  assign out_ch.data.order_changed = oc_r;
  assign out_ch.data.last_rank = (i_r + 5'd1 == n_r);

endmodule

### src/hces_checker.sv
module hces_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [3:0] out_pos
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during emit");
  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid || out_pos == 4'd0)
    else $error("round did not restart at rank zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_pos))
    else $error("result dropped");
endmodule

bind hot_color_ewma_selector_core hces_checker u_hces_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last_rank), .out_pos(out_ch.data.position)
);

### test/tb_hot_color_ewma_selector_core.sv
`timescale 1ns / 100ps

module tb_hot_color_ewma_selector_core;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [hces_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hces_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  hces_stream_if #(.T(hces_pkg::in_item_t)) in_ch ();
  hces_stream_if #(.T(hces_pkg::out_item_t)) out_ch ();

  hot_color_ewma_selector_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [4:0] p_count;
  logic [16:0] p_wrise, p_wfall, p_lv1, p_lv2, p_lv3;
  logic [3:0] p_confirm;
  logic [16:0] p_rates [16];
  logic [16:0] p_avg [16];
  logic p_primed;
  logic [3:0] p_hot, p_prev_lead, p_lead_cnt;
  logic [3:0] p_prev_order [16];

  hces_pkg::in_item_t pending_q [$];
  hces_pkg::out_item_t rank_q [$];
  int errors = 0;
  bit quiet = 1'b0;
  longint cycles = 0;

  function automatic logic [16:0] clamp_q16(logic [16:0] v);
    return (v > hces_pkg::ONE_Q16) ? hces_pkg::ONE_Q16 : v;
  endfunction

  function automatic int level_of_avg(logic [16:0] a);
    if (a >= p_lv3) return 3;
    if (a >= p_lv2) return 2;
    if (a >= p_lv1) return 1;
    return 0;
  endfunction

  task automatic predict_round(hces_pkg::in_item_t it);
    int n, j, need;
    logic [3:0] srt [16];
    logic [3:0] ord [16];
    logic [3:0] cand;
    logic [16:0] w, old, r;
    logic [63:0] s;
    bit hchg, ochg;
    hces_pkg::out_item_t o;
    p_rates[it.color_index] = clamp_q16(it.rate);
    if (!it.round_end) return;
    n = (p_count < 1) ? 1 : (p_count > 16 ? 16 : p_count);
    for (int i = 0; i < n; i++) begin
      r = p_rates[i];
      if (!p_primed) begin
        p_avg[i] = r;
      end else begin
        old = p_avg[i];
        w = clamp_q16(r > old ? p_wrise : p_wfall);
        s = 64'(w) * old + 64'(hces_pkg::ONE_Q16 - w) * r + 64'd32768;
        p_avg[i] = clamp_q16(17'(s >> 16));
      end
    end
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && p_avg[srt[j-1]] < p_avg[i]) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = 4'(i);
    end
    cand = srt[0];
    hchg = 1'b0;
    if (!p_primed) begin
      p_hot = cand; p_prev_lead = cand; p_lead_cnt = 0; hchg = 1'b1;
    end else begin
      need = (p_confirm == 0) ? 1 : p_confirm;
      if (cand != p_hot && level_of_avg(p_avg[cand]) >= level_of_avg(p_avg[p_hot]) + 1) begin
        if (cand == p_prev_lead) begin
          if (p_lead_cnt < 15) p_lead_cnt++;
        end else begin
          p_prev_lead = cand; p_lead_cnt = 1;
        end
      end else begin
        p_lead_cnt = 0; p_prev_lead = cand;
      end
      if (p_lead_cnt >= need) begin
        p_hot = cand; p_lead_cnt = 0; p_prev_lead = cand; hchg = 1'b1;
      end
    end
    ord[0] = p_hot;
    j = 1;
    for (int i = 0; i < n && j < n; i++) begin
      if (srt[i] != p_hot) begin
        ord[j] = srt[i];
        j++;
      end
    end
    ochg = !p_primed;
    for (int i = 0; i < n; i++) if (ord[i] != p_prev_order[i]) ochg = 1'b1;
    for (int i = 0; i < n; i++) p_prev_order[i] = ord[i];
    p_primed = 1'b1;
    for (int i = 0; i < n; i++) begin
      o.position = 4'(i);
      o.order_color = ord[i];
      o.hottest_color = p_hot;
      o.hottest_changed = hchg;
      o.order_changed = ochg;
      o.last_rank = (i == n - 1);
      rank_q.push_back(o);
    end
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      predict_round(in_ch.data);
      void'(pending_q.pop_front());
    end
    // a waiting request holds until taken
    if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0 && rst_n) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(1, 12);
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_q[0];
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_ch.valid && out_ch.ready) begin
      if (rank_q.size() == 0) begin
        $error("rank request with nothing expected");
        errors++;
      end else begin
        hces_pkg::out_item_t e;
        e = rank_q.pop_front();
        if (out_ch.data.position != e.position) begin
          $error("position exp %0d got %0d", e.position, out_ch.data.position); errors++;
        end
        if (out_ch.data.order_color != e.order_color) begin
          $error("order_color exp %0d got %0d", e.order_color, out_ch.data.order_color);
          errors++;
        end
        if (out_ch.data.hottest_color != e.hottest_color) begin
          $error("hottest_color exp %0d got %0d", e.hottest_color,
                 out_ch.data.hottest_color); errors++;
        end
        if (out_ch.data.hottest_changed != e.hottest_changed) begin
          $error("hottest_changed exp %0d got %0d", e.hottest_changed,
                 out_ch.data.hottest_changed); errors++;
        end
        if (out_ch.data.order_changed != e.order_changed) begin
          $error("order_changed exp %0d got %0d", e.order_changed,
                 out_ch.data.order_changed); errors++;
        end
        if (out_ch.data.last_rank != e.last_rank) begin
          $error("last_rank exp %0d got %0d", e.last_rank, out_ch.data.last_rank); errors++;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(1, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  task automatic cfg_write(logic [hces_pkg::CFG_IDX_W-1:0] idx, logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hces_pkg::REG_COLOR_COUNT: p_count = val[4:0];
      hces_pkg::REG_WEIGHT_RISE: p_wrise = val;
      hces_pkg::REG_WEIGHT_FALL: p_wfall = val;
      hces_pkg::REG_LEVEL_ONE: p_lv1 = val;
      hces_pkg::REG_LEVEL_TWO: p_lv2 = val;
      hces_pkg::REG_LEVEL_THREE: p_lv3 = val;
      hces_pkg::REG_CONFIRM: p_confirm = val[3:0];
      default: ;
    endcase
  endtask

  task automatic drain_all();
    while (pending_q.size() > 0 || rank_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [16:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return hces_pkg::ONE_Q16;
      2: return 17'($urandom_range(65537, 131071));
      3: return 17'($urandom_range(50000, 65536));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // full round of n colors; rates biased toward a chosen hot color
  task automatic queue_round(int n, int hot_c);
    hces_pkg::in_item_t it;
    for (int c = 0; c < n; c++) begin
      it.color_index = 4'(c);
      it.rate = (c == hot_c) ? 17'($urandom_range(55000, 65536)) : pick_rate();
      it.round_end = (c == n - 1);
      pending_q.push_back(it);
    end
  endtask

  int n_used, hot_c;
  hces_pkg::in_item_t it;
  initial begin
    p_count = 16; p_wrise = 55706; p_wfall = 55706;
    p_lv1 = 26214; p_lv2 = 42598; p_lv3 = 55706; p_confirm = 3;
    p_primed = 0; p_hot = 0; p_prev_lead = 0; p_lead_cnt = 0;
    for (int i = 0; i < 16; i++) begin
      p_rates[i] = 0; p_avg[i] = 0; p_prev_order[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: small count, extremes, out-of-range rates, ties
    cfg_write(hces_pkg::REG_COLOR_COUNT, 17'd4);
    cfg_write(hces_pkg::REG_CONFIRM, 17'd0);
    for (int c = 0; c < 4; c++) begin
      it.color_index = 4'(c); it.rate = 17'd30000; it.round_end = (c == 3);
      pending_q.push_back(it);
    end
    it.color_index = 4'd15; it.rate = 17'h1FFFF; it.round_end = 0; pending_q.push_back(it);
    it.color_index = 4'd2; it.rate = 17'h1FFFF; it.round_end = 0; pending_q.push_back(it);
    it.color_index = 4'd0; it.rate = 17'd0; it.round_end = 0; pending_q.push_back(it);
    it.color_index = 4'd3; it.rate = hces_pkg::ONE_Q16; it.round_end = 1;
    pending_q.push_back(it);
    it.color_index = 4'd1; it.rate = 17'd0; it.round_end = 1; pending_q.push_back(it);
    drain_all();
    cfg_write(hces_pkg::REG_COLOR_COUNT, 17'd1);
    queue_round(1, 0);
    drain_all();
    cfg_write(hces_pkg::REG_COLOR_COUNT, 17'd0);
    queue_round(2, 1);
    drain_all();
    cfg_write(hces_pkg::REG_COLOR_COUNT, 17'd31);
    cfg_write(hces_pkg::REG_WEIGHT_RISE, 17'd0);
    cfg_write(hces_pkg::REG_WEIGHT_FALL, 17'h1FFFF);
    queue_round(16, 15);
    drain_all();
    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      n_used = (ph % 4 == 0) ? 16 : $urandom_range(1, 8);
      cfg_write(hces_pkg::REG_COLOR_COUNT, 17'(n_used));
      cfg_write(hces_pkg::REG_WEIGHT_RISE,
                (ph == 1) ? hces_pkg::ONE_Q16 : 17'($urandom_range(0, 65536)));
      cfg_write(hces_pkg::REG_WEIGHT_FALL, (ph == 2) ? 17'd0 : 17'($urandom_range(0, 65536)));
      cfg_write(hces_pkg::REG_LEVEL_ONE,
                (ph == 3) ? 17'd0 : 17'($urandom_range(10000, 30000)));
      cfg_write(hces_pkg::REG_LEVEL_TWO, 17'($urandom_range(30000, 50000)));
      cfg_write(hces_pkg::REG_LEVEL_THREE,
                (ph == 4) ? 17'h1FFFF : 17'($urandom_range(50000, 65536)));
      cfg_write(hces_pkg::REG_CONFIRM, (ph == 5) ? 17'd15 : 17'($urandom_range(1, 4)));
      if (ph == 7) quiet = 1'b1;
      hot_c = $urandom_range(0, n_used - 1);
      for (int r = 0; r < 3; r++) begin
        if (r == 2) hot_c = $urandom_range(0, n_used - 1);
        if ($urandom_range(0, 5) == 0) begin
          it.color_index = 4'($urandom_range(0, 15));
          it.rate = pick_rate();
          it.round_end = 0;
          pending_q.push_back(it);
        end
        queue_round(n_used, hot_c);
      end
      drain_all();
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/hces_pkg.sv
src/hces_stream_if.sv
src/hot_color_ewma_selector_core.sv
src/hces_checker.sv
test/tb_hot_color_ewma_selector_core.sv
